/* hdl/z80alu_pkg.sv */
// Package for the Z80 8-bit ALU: operation codes, flag masks, result struct
// and flag helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package z80alu_pkg;

	// Flag byte layout, bit 7 down: S Z Y H X P/V N C
	localparam logic [7:0] FLAG_S = 8'h80;
	localparam logic [7:0] FLAG_Z = 8'h40;
	localparam logic [7:0] FLAG_Y = 8'h20;
	localparam logic [7:0] FLAG_H = 8'h10;
	localparam logic [7:0] FLAG_X = 8'h08;
	localparam logic [7:0] FLAG_P = 8'h04;
	localparam logic [7:0] FLAG_N = 8'h02;
	localparam logic [7:0] FLAG_C = 8'h01;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADC  = 5'd1,
		OP_SUB  = 5'd2,
		OP_SBC  = 5'd3,
		OP_CP   = 5'd4,
		OP_AND  = 5'd5,
		OP_OR   = 5'd6,
		OP_XOR  = 5'd7,
		OP_INC  = 5'd8,
		OP_DEC  = 5'd9,
		OP_NEG  = 5'd10,
		OP_CPL  = 5'd11,
		OP_DAA  = 5'd12,
		OP_RLC  = 5'd13,
		OP_RRC  = 5'd14,
		OP_RL   = 5'd15,
		OP_RR   = 5'd16,
		OP_SLA  = 5'd17,
		OP_SRA  = 5'd18,
		OP_SLL  = 5'd19,
		OP_SRL  = 5'd20,
		OP_RLCA = 5'd21,
		OP_RRCA = 5'd22,
		OP_RLA  = 5'd23,
		OP_RRA  = 5'd24,
		OP_BIT  = 5'd25,
		OP_RES  = 5'd26,
		OP_SET  = 5'd27,
		OP_CCF  = 5'd28
	} alu_op_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] flags;
		logic       wr;
	} alu_res_t;

	// S, Z and the undocumented Y/X copies of a result
	function automatic logic [7:0] szyx_f(input logic [7:0] r);
		logic [7:0] f;
		begin
			f = r & (FLAG_S | FLAG_Y | FLAG_X);
			if (r == 8'h00) f = f | FLAG_Z;
			szyx_f = f;
		end
	endfunction

	// as above, plus even parity in P/V
	function automatic logic [7:0] szyxp_f(input logic [7:0] r);
		logic [7:0] f;
		begin
			f = szyx_f(r);
			if (!(^r)) f = f | FLAG_P;
			szyxp_f = f;
		end
	endfunction

endpackage

`default_nettype wire

/* hdl/z80_alu8_with_flags_core.sv */
// Channel   Ports                                              Transfer
// input     start, busy, op, operand_a, operand_b,             start && !busy
//           bit_index, flags_in
// result    done, result, flags_out, result_valid              done (one cycle)
//
// Operands are registered, and the ALU logic sits between the input register and
// the result register. One operation per cycle.
// busy stays low; the result side has no back pressure.
// Asynchronous reset clears the valid bits of both stages.
// Top level of the Z80 8-bit ALU. Depends on z80alu_pkg and z80alu_calc.
`timescale 1ns / 1ps
`default_nettype none

module z80_alu8_with_flags_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [4:0] op,
	input  wire logic [7:0] operand_a,
	input  wire logic [7:0] operand_b,
	input  wire logic [2:0] bit_index,
	input  wire logic [7:0] flags_in,
	output logic            done,
	output logic [7:0]      result,
	output logic [7:0]      flags_out,
	output logic            result_valid
);
	import z80alu_pkg::*;

	logic       valid_s1;
	logic [4:0] op_s1;
	logic [7:0] a_s1;
	logic [7:0] b_s1;
	logic [2:0] idx_s1;
	logic [7:0] flags_s1;
	alu_res_t   calc_res;
	logic       valid_s2;
	alu_res_t   res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= op;
			a_s1     <= operand_a;
			b_s1     <= operand_b;
			idx_s1   <= bit_index;
			flags_s1 <= flags_in;
		end
		if (valid_s1) begin
			res_s2 <= calc_res;
		end
	end

	z80alu_calc u_calc (
		.op        (op_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.bit_index (idx_s1),
		.flags_in  (flags_s1),
		.res       (calc_res)
	);

	assign done         = valid_s2;
	assign result       = res_s2.result;
	assign flags_out    = res_s2.flags;
	assign result_valid = res_s2.wr;

`ifndef ASSERT_OFF
	a_strobe_follows_stage1 : assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(valid_s1 && arst_n))
		else $error("done does not follow stage 1 valid");

	a_no_write_on_test_ops : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (op_s1 == OP_CP || op_s1 == OP_BIT || op_s1 == OP_CCF))
		|=> (done && !result_valid))
		else $error("compare, bit test or ccf reported a write");

	a_unused_op_passthru : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && op_s1 > OP_CCF)
		|=> (result == $past(a_s1) && flags_out == $past(flags_s1) && !result_valid))
		else $error("unassigned code altered result or flags");

	a_res_set_keep_flags : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (op_s1 == OP_RES || op_s1 == OP_SET))
		|=> (flags_out == $past(flags_s1) && result_valid))
		else $error("res/set changed the flags");
`endif

endmodule

`default_nettype wire

/* hdl/z80alu_calc.sv */
// Combinational datapath of the Z80 8-bit ALU: result, flags and write enable
// for one operation. Depends on z80alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module z80alu_calc (
	input  wire logic [4:0]          op,
	input  wire logic [7:0]          operand_a,
	input  wire logic [7:0]          operand_b,
	input  wire logic [2:0]          bit_index,
	input  wire logic [7:0]          flags_in,
	output z80alu_pkg::alu_res_t     res
);
	import z80alu_pkg::*;

	alu_op_t    op_e;
	logic       cin_use;
	logic [8:0] add_sum;
	logic [8:0] add_cb;
	logic [7:0] add_f;
	logic [7:0] sub_a;
	logic [7:0] sub_b;
	logic [8:0] sub_diff;
	logic [8:0] sub_cb;
	logic [7:0] sub_f;

	assign op_e    = alu_op_t'(op);
	assign cin_use = (op_e == OP_ADC || op_e == OP_SBC) ? flags_in[0] : 1'b0;

	// shared adder
	assign add_sum = {1'b0, operand_a} + {1'b0, operand_b} + {8'd0, cin_use};
	assign add_cb  = {1'b0, operand_a ^ operand_b} ^ add_sum;
	always_comb begin
		add_f = szyx_f(add_sum[7:0]);
		if (add_cb[4]) add_f = add_f | FLAG_H;
		if (add_sum[8]) add_f = add_f | FLAG_C;
		if (~(operand_a[7] ^ operand_b[7]) & (operand_a[7] ^ add_sum[7]))
			add_f = add_f | FLAG_P;
	end

	// shared subtractor; NEG is 0 - a
	assign sub_a    = (op_e == OP_NEG) ? 8'h00 : operand_a;
	assign sub_b    = (op_e == OP_NEG) ? operand_a : operand_b;
	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b} - {8'd0, cin_use};
	assign sub_cb   = {1'b0, sub_a ^ sub_b} ^ sub_diff;
	always_comb begin
		sub_f = szyx_f(sub_diff[7:0]) | FLAG_N;
		if (sub_cb[4]) sub_f = sub_f | FLAG_H;
		if (sub_diff[8]) sub_f = sub_f | FLAG_C;
		if ((sub_a[7] ^ sub_b[7]) & (sub_a[7] ^ sub_diff[7]))
			sub_f = sub_f | FLAG_P;
	end

	always_comb begin
		logic [7:0] r;
		logic [7:0] f;
		logic       wr;
		logic       cin;
		logic       outb;
		logic       inb;
		logic [7:0] daa_adj;
		logic       daa_c;
		logic       daa_h;
		logic       tbit;
		logic [7:0] bmask;

		r       = operand_a;
		f       = flags_in;
		wr      = 1'b1;
		cin     = flags_in[0];
		outb    = 1'b0;
		inb     = 1'b0;
		daa_adj = 8'h00;
		daa_c   = flags_in[0];
		daa_h   = 1'b0;
		tbit    = operand_a[bit_index];
		bmask   = 8'h01 << bit_index;

		unique case (op_e) inside
			OP_ADD, OP_ADC: begin
				r = add_sum[7:0];
				f = add_f;
			end
			OP_SUB, OP_SBC, OP_NEG: begin
				r = sub_diff[7:0];
				f = sub_f;
			end
			OP_CP: begin
				// Y/X come from the operand, not the difference
				f  = (sub_f & ~(FLAG_Y | FLAG_X)) | (operand_b & (FLAG_Y | FLAG_X));
				wr = 1'b0;
			end
			OP_AND: begin
				r = operand_a & operand_b;
				f = szyxp_f(r) | FLAG_H;
			end
			OP_OR: begin
				r = operand_a | operand_b;
				f = szyxp_f(r);
			end
			OP_XOR: begin
				r = operand_a ^ operand_b;
				f = szyxp_f(r);
			end
			OP_INC: begin
				r = operand_a + 8'd1;
				f = szyx_f(r) | (flags_in & FLAG_C);
				if (operand_a[3:0] == 4'hF) f = f | FLAG_H;
				if (r == 8'h80) f = f | FLAG_P;
			end
			OP_DEC: begin
				r = operand_a - 8'd1;
				f = szyx_f(r) | (flags_in & FLAG_C) | FLAG_N;
				if (operand_a[3:0] == 4'h0) f = f | FLAG_H;
				if (r == 8'h7F) f = f | FLAG_P;
			end
			OP_CPL: begin
				r = ~operand_a;
				f = (flags_in & (FLAG_S | FLAG_Z | FLAG_P | FLAG_C)) | FLAG_H | FLAG_N |
				    (r & (FLAG_Y | FLAG_X));
			end
			OP_DAA: begin
				if (operand_a[3:0] > 4'h9 || flags_in[4]) daa_adj = daa_adj + 8'h06;
				if (operand_a > 8'h99 || flags_in[0]) begin
					daa_adj = daa_adj + 8'h60;
					daa_c   = 1'b1;
				end
				if (flags_in[1]) begin
					daa_h = flags_in[4] && (operand_a[3:0] < 4'h6);
					r     = operand_a - daa_adj;
				end else begin
					daa_h = operand_a[3:0] >= 4'hA;
					r     = operand_a + daa_adj;
				end
				f = szyxp_f(r) | (flags_in & FLAG_N);
				if (daa_h) f = f | FLAG_H;
				if (daa_c) f = f | FLAG_C;
			end
			OP_RLC, OP_RL, OP_SLA, OP_SLL, OP_RLCA, OP_RLA: begin
				outb = operand_a[7];
				if (op_e == OP_RLC || op_e == OP_RLCA) inb = outb;
				else if (op_e == OP_RL || op_e == OP_RLA) inb = cin;
				else if (op_e == OP_SLL) inb = 1'b1;
				else inb = 1'b0;
				r = {operand_a[6:0], inb};
				if (op_e == OP_RLCA || op_e == OP_RLA)
					f = (flags_in & (FLAG_S | FLAG_Z | FLAG_P)) | (r & (FLAG_Y | FLAG_X));
				else
					f = szyxp_f(r);
				if (outb) f = f | FLAG_C;
			end
			OP_RRC, OP_RR, OP_SRA, OP_SRL, OP_RRCA, OP_RRA: begin
				outb = operand_a[0];
				if (op_e == OP_RRC || op_e == OP_RRCA) inb = outb;
				else if (op_e == OP_RR || op_e == OP_RRA) inb = cin;
				else if (op_e == OP_SRA) inb = operand_a[7];
				else inb = 1'b0;
				r = {inb, operand_a[7:1]};
				if (op_e == OP_RRCA || op_e == OP_RRA)
					f = (flags_in & (FLAG_S | FLAG_Z | FLAG_P)) | (r & (FLAG_Y | FLAG_X));
				else
					f = szyxp_f(r);
				if (outb) f = f | FLAG_C;
			end
			OP_BIT: begin
				f = (flags_in & FLAG_C) | FLAG_H;
				if (tbit) begin
					if (bit_index == 3'd7) f = f | FLAG_S;
					if (bit_index == 3'd5) f = f | FLAG_Y;
					if (bit_index == 3'd3) f = f | FLAG_X;
				end else begin
					f = f | FLAG_Z | FLAG_P;
				end
				r  = {7'd0, tbit};
				wr = 1'b0;
			end
			OP_RES: r = operand_a & ~bmask;
			OP_SET: r = operand_a | bmask;
			OP_CCF: begin
				f = (flags_in & (FLAG_S | FLAG_Z | FLAG_P | FLAG_Y | FLAG_X)) |
				    (operand_a & (FLAG_Y | FLAG_X));
				if (cin) f = f | FLAG_H;
				else f = f | FLAG_C;
				wr = 1'b0;
			end
			default: begin
				// unassigned codes: pass through, no write
				r  = operand_a;
				f  = flags_in;
				wr = 1'b0;
			end
		endcase

		res.result = r;
		res.flags  = f;
		res.wr     = wr;
	end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for z80_alu8_with_flags_core: directed corner cases, then random operations.
// Results are checked in order against a predictor built into a scoreboard class.
// Depends on z80alu_pkg for the operation codes, flag masks and result struct.
`timescale 1ns / 1ps

import z80alu_pkg::*;

class alu_scoreboard;
	alu_res_t pending[$];
	int mismatches;

	function new();
		mismatches = 0;
	endfunction

	static function logic [7:0] szyx(input logic [7:0] r);
		return (r & (FLAG_S | FLAG_Y | FLAG_X)) | ((r == 8'h00) ? FLAG_Z : 8'h00);
	endfunction

	static function logic [7:0] szyxp(input logic [7:0] r);
		return szyx(r) | ((~^r) ? FLAG_P : 8'h00);
	endfunction

	// x - y - c, returns {difference, flags}
	static function logic [15:0] sub_flags(input logic [7:0] x, y, input logic c);
		logic [8:0] wide;
		logic [8:0] carries;
		logic [7:0] r;
		logic [7:0] f;
		wide = {1'b0, x} - {1'b0, y} - {8'h00, c};
		r = wide[7:0];
		carries = {1'b0, x} ^ {1'b0, y} ^ wide;
		f = szyx(r) | FLAG_N | (carries[4] ? FLAG_H : 8'h00) | (carries[8] ? FLAG_C : 8'h00)
			| ((((x ^ y) & (x ^ r) & 8'h80) != 8'h00) ? FLAG_P : 8'h00);
		return {r, f};
	endfunction

	// CB shifts set S Z P from the result; the fast accumulator rotates keep them
	static function logic [7:0] shift_flags(input logic [4:0] o, input logic [7:0] r,
			input logic co, input logic [7:0] fin);
		if (o >= OP_RLCA)
			return (fin & (FLAG_S | FLAG_Z | FLAG_P)) | (r & (FLAG_Y | FLAG_X)) | {7'h00, co};
		return szyxp(r) | {7'h00, co};
	endfunction

	static function alu_res_t predict(input logic [4:0] o, input logic [7:0] a, b,
			input logic [2:0] idx, input logic [7:0] fin);
		alu_res_t res;
		logic [8:0] wide;
		logic [8:0] carries;
		logic [7:0] r;
		logic [7:0] f;
		logic [7:0] adj;
		logic cin;
		logic co;
		logic cy;
		logic hn;
		logic tested;
		cin = fin[0];
		r = a;
		f = fin;
		res.wr = 1'b1;
		case (o)
			OP_ADD, OP_ADC: begin
				wide = {1'b0, a} + {1'b0, b} + {8'h00, cin & (o == OP_ADC)};
				r = wide[7:0];
				carries = {1'b0, a} ^ {1'b0, b} ^ wide;
				f = szyx(r) | (carries[4] ? FLAG_H : 8'h00) | (carries[8] ? FLAG_C : 8'h00)
					| ((((~(a ^ b)) & (a ^ r) & 8'h80) != 8'h00) ? FLAG_P : 8'h00);
			end
			OP_SUB: {r, f} = sub_flags(a, b, 1'b0);
			OP_SBC: {r, f} = sub_flags(a, b, cin);
			OP_CP: begin
				{r, f} = sub_flags(a, b, 1'b0);
				// Y/X come from the operand, not the difference
				f = (f & ~(FLAG_Y | FLAG_X)) | (b & (FLAG_Y | FLAG_X));
				r = a;
				res.wr = 1'b0;
			end
			OP_AND: begin
				r = a & b;
				f = szyxp(r) | FLAG_H;
			end
			OP_OR: begin
				r = a | b;
				f = szyxp(r);
			end
			OP_XOR: begin
				r = a ^ b;
				f = szyxp(r);
			end
			OP_INC: begin
				r = a + 8'h01;
				f = (fin & FLAG_C) | szyx(r) | ((a[3:0] == 4'hF) ? FLAG_H : 8'h00)
					| ((r == 8'h80) ? FLAG_P : 8'h00);
			end
			OP_DEC: begin
				r = a - 8'h01;
				f = (fin & FLAG_C) | szyx(r) | FLAG_N | ((a[3:0] == 4'h0) ? FLAG_H : 8'h00)
					| ((r == 8'h7F) ? FLAG_P : 8'h00);
			end
			OP_NEG: {r, f} = sub_flags(8'h00, a, 1'b0);
			OP_CPL: begin
				r = ~a;
				f = (fin & (FLAG_S | FLAG_Z | FLAG_P | FLAG_C)) | FLAG_H | FLAG_N
					| (r & (FLAG_Y | FLAG_X));
			end
			OP_DAA: begin
				adj = 8'h00;
				cy = cin;
				if (a[3:0] > 4'h9 || (fin & FLAG_H) != 8'h00) adj = adj + 8'h06;
				if (a > 8'h99 || cy) begin
					adj = adj + 8'h60;
					cy = 1'b1;
				end
				if ((fin & FLAG_N) != 8'h00) begin
					hn = (fin & FLAG_H) != 8'h00 && a[3:0] < 4'h6;
					r = a - adj;
				end else begin
					hn = a[3:0] >= 4'hA;
					r = a + adj;
				end
				f = szyxp(r) | (hn ? FLAG_H : 8'h00) | (fin & FLAG_N) | {7'h00, cy};
			end
			OP_RLC, OP_RL, OP_SLA, OP_SLL, OP_RLCA, OP_RLA: begin
				co = a[7];
				case (o)
					OP_RLC, OP_RLCA: r = {a[6:0], a[7]};
					OP_RL, OP_RLA:   r = {a[6:0], cin};
					OP_SLL:          r = {a[6:0], 1'b1};
					default:         r = {a[6:0], 1'b0};
				endcase
				f = shift_flags(o, r, co, fin);
			end
			OP_RRC, OP_RR, OP_SRA, OP_SRL, OP_RRCA, OP_RRA: begin
				co = a[0];
				case (o)
					OP_RRC, OP_RRCA: r = {a[0], a[7:1]};
					OP_RR, OP_RRA:   r = {cin, a[7:1]};
					OP_SRA:          r = {a[7], a[7:1]};
					default:         r = {1'b0, a[7:1]};
				endcase
				f = shift_flags(o, r, co, fin);
			end
			OP_BIT: begin
				tested = a[idx];
				f = (fin & FLAG_C) | FLAG_H;
				if (tested) begin
					if (idx == 3'd7) f = f | FLAG_S;
					if (idx == 3'd5) f = f | FLAG_Y;
					if (idx == 3'd3) f = f | FLAG_X;
				end else begin
					f = f | FLAG_Z | FLAG_P;
				end
				r = {7'h00, tested};
				res.wr = 1'b0;
			end
			OP_RES: r = a & ~(8'h01 << idx);
			OP_SET: r = a | (8'h01 << idx);
			OP_CCF: begin
				f = (fin & (FLAG_S | FLAG_Z | FLAG_P | FLAG_Y | FLAG_X))
					| (cin ? FLAG_H : 8'h00) | {7'h00, ~cin} | (a & (FLAG_Y | FLAG_X));
				res.wr = 1'b0;
			end
			default: res.wr = 1'b0; // unused codes: pass a and flags through
		endcase
		res.result = r;
		res.flags = f;
		return res;
	endfunction

	function void note_transfer(input logic [4:0] o, input logic [7:0] a, b,
			input logic [2:0] idx, input logic [7:0] fin);
		pending.push_back(predict(o, a, b, idx, fin));
	endfunction

	function void check_result(input logic [7:0] r, f, input logic wr);
		alu_res_t want;
		if (pending.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result r=%h f=%h wr=%b at %0t", r, f, wr, $realtime);
			mismatches++;
			return;
		end
		want = pending.pop_front();
		if (r !== want.result || f !== want.flags || wr !== want.wr) begin
			if (mismatches < 10)
				$display("mismatch at %0t: expected r=%h f=%h wr=%b, got r=%h f=%h wr=%b",
					$realtime, want.result, want.flags, want.wr, r, f, wr);
			mismatches++;
		end
	endfunction
endclass

module tb_top;
	localparam int RANDOM_OPS = 1510;
	localparam int QUIET_TAIL = 200;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [4:0] op = 5'd0;
	logic [7:0] operand_a = 8'h00;
	logic [7:0] operand_b = 8'h00;
	logic [2:0] bit_index = 3'd0;
	logic [7:0] flags_in = 8'h00;
	logic busy;
	logic done;
	logic [7:0] result;
	logic [7:0] flags_out;
	logic result_valid;

	alu_scoreboard sb;
	bit idle_ok = 1'b1;
	int cycles = 0;

	z80_alu8_with_flags_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.bit_index(bit_index),
		.flags_in(flags_in),
		.done(done),
		.result(result),
		.flags_out(flags_out),
		.result_valid(result_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// transfers and results are sampled with their pre-edge values
	always @(posedge clk) begin
		if (start === 1'b1 && busy === 1'b0)
			sb.note_transfer(op, operand_a, operand_b, bit_index, flags_in);
		if (done === 1'b1)
			sb.check_result(result, flags_out, result_valid);
	end

	task automatic send_op(input logic [4:0] o, input logic [7:0] a, b,
			input logic [2:0] idx, input logic [7:0] fin);
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		op <= o;
		operand_a <= a;
		operand_b <= b;
		bit_index <= idx;
		flags_in <= fin;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 4))
				0: return 8'h00;
				1: return 8'hFF;
				2: return 8'h80;
				3: return 8'h7F;
				default: return 8'h01;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// DAA usually follows a BCD add or subtract, so build that case often
	task automatic send_bcd_adjust();
		alu_res_t prior;
		logic [7:0] x;
		logic [7:0] y;
		logic [4:0] arith;
		x = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
		y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
		case ($urandom_range(0, 3))
			0: arith = OP_ADD;
			1: arith = OP_ADC;
			2: arith = OP_SUB;
			default: arith = OP_SBC;
		endcase
		prior = sb.predict(arith, x, y, 3'd0, 8'($urandom_range(0, 255)));
		send_op(OP_DAA, prior.result, pick_byte(), 3'($urandom_range(0, 7)), prior.flags);
	endtask

	initial begin
		logic [7:0] corners [4];
		int sel;
		sb = new();
		corners = '{8'h00, 8'hFF, 8'h80, 8'h7F};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every code, unused ones included, on extreme operands
		for (int k = 0; k < 32; k++)
			send_op(5'(k), corners[k % 4], corners[(k / 4) % 4], 3'(k),
				k[0] ? 8'hFF : 8'h00);
		send_op(OP_INC, 8'h7F, 8'h00, 3'd0, 8'h00);
		send_op(OP_DEC, 8'h80, 8'h00, 3'd0, 8'hFF);
		send_op(OP_CP, 8'h10, 8'h28, 3'd0, 8'h00);
		send_op(OP_BIT, 8'hFF, 8'h00, 3'd7, 8'h01);
		send_op(OP_BIT, 8'h28, 8'h00, 3'd5, 8'h00);
		send_op(OP_BIT, 8'h28, 8'h00, 3'd3, 8'h00);
		send_op(OP_BIT, 8'h00, 8'h00, 3'd4, 8'hFE);
		send_op(OP_DAA, 8'h9A, 8'h00, 3'd0, FLAG_N | FLAG_H);
		send_op(OP_CCF, 8'h28, 8'h00, 3'd0, 8'h01);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n >= RANDOM_OPS - QUIET_TAIL) idle_ok = 1'b0;
			sel = $urandom_range(0, 99);
			if (sel < 3)
				send_op(5'($urandom_range(29, 31)), pick_byte(), pick_byte(),
					3'($urandom_range(0, 7)), pick_byte());
			else if (sel < 8)
				send_bcd_adjust();
			else
				send_op(5'($urandom_range(0, 28)), pick_byte(), pick_byte(),
					3'($urandom_range(0, 7)), pick_byte());
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
